@@ rtl/relay_command_frame_handler_core_assert.svh @@
// assertion macros shared by the relay command frame handler modules
`ifndef RELAY_COMMAND_FRAME_HANDLER_CORE_ASSERT_SVH
`define RELAY_COMMAND_FRAME_HANDLER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, clocked on clk, off while arst_n is low
`define RCFH_ASSERT_NOW(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);
// next-cycle implication, clocked on clk, off while arst_n is low
`define RCFH_ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);
`else
`define RCFH_ASSERT_NOW(lbl, ante, cons, msg)
`define RCFH_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/rcfh_pkg.sv @@
// shared constants and types of the relay command frame handler
package rcfh_pkg;
	localparam int FRAME_BYTES = 8;
	localparam int CHANNELS    = 4;
	localparam int POS_W       = $clog2(FRAME_BYTES);
	localparam int ADDR_W      = POS_W + 1;

	localparam logic [POS_W-1:0] LAST_POS    = POS_W'(FRAME_BYTES - 1);
	localparam logic [POS_W-1:0] FIRST_POS   = POS_W'(0);
	localparam logic [POS_W-1:0] OPCODE_POS  = POS_W'(1);
	localparam logic [POS_W-1:0] PAYLOAD_POS = POS_W'(3);

	localparam logic [7:0] OP_FIND      = 8'h03;
	localparam logic [7:0] OP_WRITE     = 8'h01;
	localparam logic [7:0] FILL_BYTE    = 8'hFF;
	localparam logic [7:0] START_RESET  = 8'h0F;
	localparam logic [7:0] END_RESET    = 8'hF0;
	localparam logic [3:0] RELAY_MASK   = 4'((1 << CHANNELS) - 1);

	typedef enum logic [0:0] {
		REG_START_MARKER = 1'b0,
		REG_END_MARKER   = 1'b1
	} cfg_reg_t;

	// reply job handed from the collector to the reply sequencer
	typedef struct packed {
		logic       go;
		logic       bad;
		logic       bank;
		logic [3:0] relay;
	} job_t;

	// one queued reply word
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic [3:0] relay;
	} out_word_t;
endpackage

@@ rtl/relay_command_frame_handler_core.sv @@
// reply path: the last byte of a frame starts a job in the reply sequencer; each word passes the
// registered read stage and the output queue before it is offered
// throughput: one reply word per cycle while out_stall is low; a bad-frame reply has 16 words
// (fill run, then echo); the final byte of a frame stalls until the previous reply has
// issued all its reads (one sequencer serves both the fill and the echo run)
// reset: byte position 0, relays off, markers 0x0f and 0xf0, queue empty, buffer not cleared
module relay_command_frame_handler_core (
	input  logic       clk,
	input  logic       arst_n,
	// receive side
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	// reply side
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] tx_byte,
	output logic       reply_last,
	output logic [3:0] relay_bits,
	// register write port
	input  logic       cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [7:0] cfg_data
);
	import rcfh_pkg::*;

	// marker registers
	logic [7:0]        start_q;
	logic [7:0]        end_q;

	// buffer write side, driven by the collector
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [7:0]        wr_data;

	// buffer read side, driven by the reply sequencer
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [7:0]        rd_data;

	// job handoff and interlock
	job_t              job;
	logic              busy;

	// register writes land directly, no handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= START_RESET;
			end_q   <= END_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_START_MARKER: start_q <= cfg_data;
				REG_END_MARKER:   end_q   <= cfg_data;
				default:          ;
			endcase
		end
	end

	// collector writes each byte into the filling bank and decides at the frame end;
	// banks alternate per frame so the next frame fills while the last one is echoed
	rcfh_collector u_collector (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.start_marker (start_q),
		.end_marker   (end_q),
		.busy         (busy),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data),
		.job          (job)
	);

	// two banks of one frame each, selected by the top address bit
	rcfh_frame_ram #(
		.ADDR_W (ADDR_W),
		.DATA_W (8)
	) u_frame_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// reply sequencer: optional fill run of 0xff words, then the echo read out of the
	// finished bank; words wait in a two-entry queue, and a stalled sink that fills it stalls input
	rcfh_reply u_reply (
		.clk        (clk),
		.arst_n     (arst_n),
		.job        (job),
		.busy       (busy),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.tx_byte    (tx_byte),
		.reply_last (reply_last),
		.relay_bits (relay_bits)
	);
endmodule

@@ rtl/rcfh_frame_ram.sv @@
// two-bank frame buffer, one write and one registered read port
module rcfh_frame_ram #(
	parameter int ADDR_W = 4,
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);
	logic [DATA_W-1:0] mem_q [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

@@ rtl/rcfh_collector.sv @@
// frame collector: byte position, bank select, marker check and relay levels
module rcfh_collector (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  rx_byte,
	input  logic [7:0]                  start_marker,
	input  logic [7:0]                  end_marker,
	input  logic                        busy,
	output logic                        wr_en,
	output logic [rcfh_pkg::ADDR_W-1:0] wr_addr,
	output logic [7:0]                  wr_data,
	output rcfh_pkg::job_t              job
);
	import rcfh_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic             bank_q;
	logic [3:0]       relay_q;
	logic [7:0]       b0_q;
	logic [7:0]       b1_q;
	logic [7:0]       b3_q;
	logic             accept;
	logic             at_last;
	logic             bad;
	logic             is_find;
	logic             is_write;
	logic [7:0]       payload;
	logic [3:0]       relay_next;

	assign at_last  = (pos_q == LAST_POS);
	// frame end waits until the previous reply has issued all its reads
	assign in_stall = at_last && busy;
	assign accept   = in_valid && !in_stall;

	assign wr_en   = accept;
	assign wr_addr = {bank_q, pos_q};
	assign wr_data = rx_byte;

	assign payload    = (PAYLOAD_POS == LAST_POS) ? rx_byte : b3_q;
	assign bad        = (b0_q != start_marker) || (rx_byte != end_marker);
	assign is_find    = (b1_q == OP_FIND);
	assign is_write   = (b1_q == OP_WRITE);
	assign relay_next = (!bad && is_write) ? (payload[3:0] & RELAY_MASK) : relay_q;

	always_comb begin
		job.go    = accept && at_last && (bad || is_find || is_write);
		job.bad   = bad;
		job.bank  = bank_q;
		job.relay = relay_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= FIRST_POS;
			bank_q  <= 1'b0;
			relay_q <= 4'h0;
		end else if (accept) begin
			if (at_last) begin
				pos_q   <= FIRST_POS;
				bank_q  <= ~bank_q;
				relay_q <= relay_next;
			end else begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && pos_q == FIRST_POS) begin
			b0_q <= rx_byte;
		end
		if (accept && pos_q == OPCODE_POS) begin
			b1_q <= rx_byte;
		end
		if (accept && pos_q == PAYLOAD_POS) begin
			b3_q <= rx_byte;
		end
	end
endmodule

@@ rtl/rcfh_reply.sv @@
// reply sequencer: fill run, echo reads and two-word output queue
`include "relay_command_frame_handler_core_assert.svh"
module rcfh_reply (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rcfh_pkg::job_t              job,
	output logic                        busy,
	output logic                        rd_en,
	output logic [rcfh_pkg::ADDR_W-1:0] rd_addr,
	input  logic [7:0]                  rd_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [7:0]                  tx_byte,
	output logic                        reply_last,
	output logic [3:0]                  relay_bits
);
	import rcfh_pkg::*;

	logic             busy_q;
	logic             fill_q;
	logic [POS_W-1:0] idx_q;
	logic             bank_q;
	logic [3:0]       relay_q;
	logic             valid_s1;
	logic             fill_s1;
	logic             last_s1;
	logic [3:0]       relay_s1;
	out_word_t        fifo_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             pop;
	logic             push;
	logic             issue;
	out_word_t        word_s1;
	out_word_t        head;

	assign pop  = (cnt_q != 2'd0) && !out_stall;
	assign push = valid_s1;
	// room for one more word counting the one in flight
	assign issue = busy_q &&
		(({1'b0, cnt_q} + {2'b00, valid_s1}) < (3'd2 + {2'b00, pop}));

	assign busy    = busy_q;
	assign rd_en   = issue && !fill_q;
	assign rd_addr = {bank_q, idx_q};

	always_comb begin
		word_s1.data  = fill_s1 ? FILL_BYTE : rd_data;
		word_s1.last  = last_s1;
		word_s1.relay = relay_s1;
	end

	assign head       = fifo_q[rd_ptr_q];
	assign out_valid  = (cnt_q != 2'd0);
	assign tx_byte    = head.data;
	assign reply_last = head.last;
	assign relay_bits = head.relay;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			fill_q   <= 1'b0;
			idx_q    <= FIRST_POS;
			valid_s1 <= 1'b0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (job.go) begin
				busy_q <= 1'b1;
				fill_q <= job.bad;
				idx_q  <= FIRST_POS;
			end else if (issue) begin
				if (idx_q == LAST_POS) begin
					idx_q <= FIRST_POS;
					if (fill_q) begin
						fill_q <= 1'b0;
					end else begin
						busy_q <= 1'b0;
					end
				end else begin
					idx_q <= idx_q + POS_W'(1);
				end
			end
			valid_s1 <= issue;
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (job.go) begin
			bank_q  <= job.bank;
			relay_q <= job.relay;
		end
		fill_s1  <= fill_q;
		last_s1  <= !fill_q && (idx_q == LAST_POS);
		relay_s1 <= relay_q;
		if (push) begin
			fifo_q[wr_ptr_q] <= word_s1;
		end
	end

	`RCFH_ASSERT_NOW(a_go_when_idle, job.go, !busy_q, "reply job started while busy")
	`RCFH_ASSERT_NOW(a_no_overflow, push, (cnt_q != 2'd2) || pop, "output queue overflow")
	`RCFH_ASSERT_NEXT(a_echo_end, issue && !fill_q && idx_q == LAST_POS, !busy_q, "sequencer kept busy after last read")
	`RCFH_ASSERT_NOW(a_last_after_done, push && last_s1, !busy_q, "last word pushed while job still active")
endmodule
